FILE: rtl/ntsc_aa_pkg.sv
// shared constants, types and helper functions of the ntsc artifact accumulator
`default_nettype none

package ntsc_aa_pkg;

  localparam int LANES           = 8;
  localparam int LANE_BITS       = $clog2(LANES);
  localparam int VECTORS_PER_COLOUR = 16;
  localparam int VEC_BITS        = $clog2(VECTORS_PER_COLOUR);
  localparam int COLOURS_DEFAULT = 256;
  localparam int PIX_W           = 8;
  localparam int ADDR_W          = PIX_W + VEC_BITS + LANE_BITS;
  localparam int ACC_W           = 16;
  localparam int BYTE_W          = 8;
  localparam int CMD_W           = 2;
  localparam int PIXELS          = 4;
  // each pixel owns a slot of four vectors, of which the first three are used
  localparam int VEC_SLOT        = 4;
  localparam int TAPS            = 3;
  localparam int SQ_SHIFT        = 4;
  localparam int QUEUE_DEPTH     = 8;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GROUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  typedef struct packed {
    logic                en;
    logic [PIX_W-1:0]    colour;
    logic [VEC_BITS-1:0] vec;
    logic [ACC_W-1:0]    value;
  } tbl_wr_t;

  typedef struct packed {
    logic                         en;
    logic [PIXELS-1:0][PIX_W-1:0] colour;
  } tbl_rd_t;

  typedef struct packed {
    logic group;
    logic flush;
  } acc_op_t;

  typedef struct packed {
    logic [LANES-1:0][BYTE_W-1:0] lane_byte;
    logic                         last;
  } result_t;

  // arithmetic shift by four, clamped to a byte
  function automatic logic [BYTE_W-1:0] squash(input logic [ACC_W-1:0] a);
    logic [ACC_W-SQ_SHIFT-1:0] s;
    s = a[ACC_W-1:SQ_SHIFT];
    if (a[ACC_W-1]) begin
      return '0;
    end else if (s > {{(ACC_W-SQ_SHIFT-BYTE_W){1'b0}}, {BYTE_W{1'b1}}}) begin
      return '1;
    end else begin
      return s[BYTE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ntsc_aa_if.sv
// handshake interfaces for the item and result channels
`default_nettype none

interface ntsc_aa_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [ntsc_aa_pkg::CMD_W-1:0]        command;
  logic [ntsc_aa_pkg::ADDR_W-1:0]       table_address;
  logic signed [ntsc_aa_pkg::ACC_W-1:0] table_value;
  logic [ntsc_aa_pkg::PIX_W-1:0]        pixel_first;
  logic [ntsc_aa_pkg::PIX_W-1:0]        pixel_second;
  logic [ntsc_aa_pkg::PIX_W-1:0]        pixel_third;
  logic [ntsc_aa_pkg::PIX_W-1:0]        pixel_fourth;

  modport source(output valid, command, table_address, table_value, pixel_first,
                 pixel_second, pixel_third, pixel_fourth, input ready);
  modport sink(input valid, command, table_address, table_value, pixel_first,
               pixel_second, pixel_third, pixel_fourth, output ready);
endinterface

interface ntsc_aa_result_if;
  logic                           valid;
  logic                           ready;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_0;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_1;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_2;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_3;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_4;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_5;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_6;
  logic [ntsc_aa_pkg::BYTE_W-1:0] out_byte_7;
  logic                           last_of_run;

  modport source(output valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3,
                 out_byte_4, out_byte_5, out_byte_6, out_byte_7, last_of_run,
                 input ready);
  modport sink(input valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3,
               out_byte_4, out_byte_5, out_byte_6, out_byte_7, last_of_run,
               output ready);
endinterface

`default_nettype wire

FILE: rtl/ntsc_aa_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ntsc_aa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ntsc_aa_lane.sv
// one lane: impulse banks, tap adders and the current/pending accumulators
`default_nettype none

module ntsc_aa_lane #(
  parameter int COLOURS = ntsc_aa_pkg::COLOURS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ntsc_aa_pkg::tbl_wr_t                wr,
  input  ntsc_aa_pkg::tbl_rd_t                rd,
  input  logic [ntsc_aa_pkg::PIXELS-1:0]      hit,
  input  ntsc_aa_pkg::acc_op_t                op,
  output logic [ntsc_aa_pkg::BYTE_W-1:0]      byte_cur,
  output logic [ntsc_aa_pkg::BYTE_W-1:0]      byte_pend
);

  localparam int CW = $clog2(COLOURS);

  logic [ntsc_aa_pkg::ACC_W-1:0] tap [ntsc_aa_pkg::PIXELS][ntsc_aa_pkg::TAPS];
  logic [ntsc_aa_pkg::ACC_W-1:0] sum_next [ntsc_aa_pkg::TAPS];
  logic [ntsc_aa_pkg::ACC_W-1:0] sum [ntsc_aa_pkg::TAPS];
  logic [ntsc_aa_pkg::ACC_W-1:0] acc_cur;
  logic [ntsc_aa_pkg::ACC_W-1:0] acc_pend;
  logic [ntsc_aa_pkg::ACC_W-1:0] cur_sum;

  // one bank per (pixel slot, tap), indexed by colour
  for (genvar k = 0; k < ntsc_aa_pkg::PIXELS; k++) begin : g_pix
    for (genvar j = 0; j < ntsc_aa_pkg::TAPS; j++) begin : g_tap
      ntsc_aa_ram #(
        .WIDTH(ntsc_aa_pkg::ACC_W),
        .DEPTH(COLOURS)
      ) u_bank (
        .clk  (clk),
        .we   (wr.en && (wr.vec == ntsc_aa_pkg::VEC_BITS'(k * ntsc_aa_pkg::VEC_SLOT + j))),
        .waddr(wr.colour[CW-1:0]),
        .wdata(wr.value),
        .re   (rd.en),
        .raddr(rd.colour[k][CW-1:0]),
        .rdata(tap[k][j])
      );
    end
  end

  // out-of-range colours add nothing
  always_comb begin
    for (int j = 0; j < ntsc_aa_pkg::TAPS; j++) begin
      sum_next[j] = '0;
      for (int k = 0; k < ntsc_aa_pkg::PIXELS; k++) begin
        if (hit[k]) begin
          sum_next[j] = sum_next[j] + tap[k][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ntsc_aa_pkg::TAPS; j++) begin
      sum[j] <= sum_next[j];
    end
  end

  assign cur_sum = acc_cur + sum[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cur  <= '0;
      acc_pend <= '0;
    end else if (op.group) begin
      acc_cur  <= acc_pend + sum[1];
      acc_pend <= sum[2];
    end else if (op.flush) begin
      acc_cur  <= '0;
      acc_pend <= '0;
    end
  end

  assign byte_cur  = ntsc_aa_pkg::squash(op.group ? cur_sum : acc_cur);
  assign byte_pend = ntsc_aa_pkg::squash(acc_pend);

endmodule

`default_nettype wire

FILE: rtl/ntsc_aa_merge.sv
// result queue that merges lane bytes into beats, up to two writes per cycle
`default_nettype none

module ntsc_aa_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_one,
  input  logic                push_two,
  input  ntsc_aa_pkg::result_t first,
  input  ntsc_aa_pkg::result_t second,
  input  logic [1:0]          busy,
  output logic                room,
  output logic                head_valid,
  output ntsc_aa_pkg::result_t head,
  input  logic                head_take
);

  localparam int DEPTH = ntsc_aa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 3;

  ntsc_aa_pkg::result_t entry [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;
  logic [SUM_W-1:0] worst;

  assign pop        = head_valid && head_take;
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];

  // each item still in the lanes may yet bring two beats, so does the next one
  assign worst = SUM_W'(count) + SUM_W'({busy, 1'b0}) + SUM_W'(2);
  assign room  = (worst <= SUM_W'(DEPTH));

  always_comb begin
    count_next = count + CNT_W'(push_one) + CNT_W'(push_two) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_one) begin
      entry[wr_ptr] <= first;
    end
    if (push_two) begin
      entry[wr_ptr + PTR_W'(1)] <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_one) + PTR_W'(push_two);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ntsc_artifact_accumulator_unit.sv
// top level of the ntsc artifact accumulator
//
//  channel  dir  kind          payload
//  -------  ---  ------------  ---------------------------------------------------
//  item     in   valid/ready   command, table_address, table_value, pixel_first..4
//  result   out  valid/ready   out_byte_0..out_byte_7, last_of_run
//
// one item per cycle is taken while item ready is high; a load writes its bank
// at the accept edge, a group reads all 96 banks there, registers the bank data,
// then the per-lane tap sums, then joins the result queue; a flush puts two beats
// into the queue at once. item ready falls while the 8-beat result queue could not
// hold two beats for every item still in the lanes plus the next one; a result
// stall that fills the queue holds back every command, loads included
// reset (rst, synchronous) clears accumulators, pipeline and queue; the impulse
// banks keep their contents and must be loaded before they are read
`default_nettype none

module ntsc_artifact_accumulator_unit #(
  parameter int COLOURS = ntsc_aa_pkg::COLOURS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  ntsc_aa_item_if.sink            item,
  ntsc_aa_result_if.source        result
);

  localparam int LANES = ntsc_aa_pkg::LANES;
  localparam int PIXW  = ntsc_aa_pkg::PIX_W;
  localparam int LB    = ntsc_aa_pkg::LANE_BITS;
  localparam int VB    = ntsc_aa_pkg::VEC_BITS;
  localparam int AW    = ntsc_aa_pkg::ADDR_W;

  // input handshake
  logic accept;
  logic room;

  // table address fields
  logic [PIXW-1:0] ld_colour;
  logic [VB-1:0]   ld_vec;
  logic [LB-1:0]   ld_lane;
  logic            ld_ok;

  ntsc_aa_pkg::tbl_wr_t wr [LANES];
  ntsc_aa_pkg::tbl_rd_t rd;

  logic [ntsc_aa_pkg::PIXELS-1:0] hit_next;

  // pipeline control: stage 1 holds bank read data, stage 2 the tap sums
  logic                               s1_valid;
  logic [ntsc_aa_pkg::CMD_W-1:0]      s1_cmd;
  logic [ntsc_aa_pkg::PIXELS-1:0]     s1_hit;
  logic                               s2_valid;
  logic [ntsc_aa_pkg::CMD_W-1:0]      s2_cmd;
  ntsc_aa_pkg::acc_op_t               op;

  logic [LANES-1:0][ntsc_aa_pkg::BYTE_W-1:0] cur_byte;
  logic [LANES-1:0][ntsc_aa_pkg::BYTE_W-1:0] pend_byte;

  ntsc_aa_pkg::result_t first;
  ntsc_aa_pkg::result_t second;
  ntsc_aa_pkg::result_t head;
  logic                 head_valid;
  logic [1:0]           busy;

  assign item.ready = !rst && room;
  assign accept     = item.valid && item.ready;

  // address is colour, vector, lane from the top bit down
  assign ld_colour = item.table_address[AW-1 -: PIXW];
  assign ld_vec    = item.table_address[LB+VB-1 -: VB];
  assign ld_lane   = item.table_address[LB-1:0];
  assign ld_ok     = accept && (item.command == ntsc_aa_pkg::CMD_LOAD)
                     && ({1'b0, ld_colour} < (PIXW+1)'(COLOURS));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wr[l].en     = ld_ok && (ld_lane == LB'(l));
      wr[l].colour = ld_colour;
      wr[l].vec    = ld_vec;
      wr[l].value  = $unsigned(item.table_value);
    end
  end

  // all lanes read the same four colours for a group
  assign rd.en        = accept && (item.command == ntsc_aa_pkg::CMD_GROUP);
  assign rd.colour[0] = item.pixel_first;
  assign rd.colour[1] = item.pixel_second;
  assign rd.colour[2] = item.pixel_third;
  assign rd.colour[3] = item.pixel_fourth;

  always_comb begin
    for (int k = 0; k < ntsc_aa_pkg::PIXELS; k++) begin
      hit_next[k] = ({1'b0, rd.colour[k]} < (PIXW+1)'(COLOURS));
    end
  end

  // only groups and flushes travel down the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && ((item.command == ntsc_aa_pkg::CMD_GROUP)
                             || (item.command == ntsc_aa_pkg::CMD_FLUSH));
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd <= item.command;
    s1_hit <= hit_next;
    s2_cmd <= s1_cmd;
  end

  assign op.group = s2_valid && (s2_cmd == ntsc_aa_pkg::CMD_GROUP);
  assign op.flush = s2_valid && (s2_cmd == ntsc_aa_pkg::CMD_FLUSH);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ntsc_aa_lane #(
      .COLOURS(COLOURS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr[l]),
      .rd       (rd),
      .hit      (s1_hit),
      .op       (op),
      .byte_cur (cur_byte[l]),
      .byte_pend(pend_byte[l])
    );
  end

  // a group gives one closing beat; a flush gives current then pending
  assign first.lane_byte  = cur_byte;
  assign first.last       = op.group;
  assign second.lane_byte = pend_byte;
  assign second.last      = 1'b1;

  assign busy = {1'b0, s1_valid} + {1'b0, s2_valid};

  ntsc_aa_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .push_one  (op.group || op.flush),
    .push_two  (op.flush),
    .first     (first),
    .second    (second),
    .busy      (busy),
    .room      (room),
    .head_valid(head_valid),
    .head      (head),
    .head_take (result.ready)
  );

  assign result.valid       = head_valid;
  assign result.out_byte_0  = head.lane_byte[0];
  assign result.out_byte_1  = head.lane_byte[1];
  assign result.out_byte_2  = head.lane_byte[2];
  assign result.out_byte_3  = head.lane_byte[3];
  assign result.out_byte_4  = head.lane_byte[4];
  assign result.out_byte_5  = head.lane_byte[5];
  assign result.out_byte_6  = head.lane_byte[6];
  assign result.out_byte_7  = head.lane_byte[7];
  assign result.last_of_run = head.last;

endmodule

`default_nettype wire

FILE: rtl/ntsc_aa_checker.sv
// port-level checker for the ntsc artifact accumulator and its bind
`default_nettype none

module ntsc_aa_checker (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          item_valid,
  input logic                                          item_ready,
  input logic [ntsc_aa_pkg::CMD_W-1:0]                 item_command,
  input logic                                          result_valid,
  input logic                                          result_ready,
  input logic [ntsc_aa_pkg::LANES*ntsc_aa_pkg::BYTE_W-1:0] result_data,
  input logic                                          result_last
);

  logic       item_beat;
  logic       result_beat;
  logic [7:0] owed;
  logic [7:0] owed_next;
  logic       half_open;

  assign item_beat   = item_valid && item_ready;
  assign result_beat = result_valid && result_ready;

  // beats owed to the sink for items already taken
  always_comb begin
    owed_next = owed;
    if (item_beat && (item_command == ntsc_aa_pkg::CMD_GROUP)) begin
      owed_next = owed_next + 8'd1;
    end
    if (item_beat && (item_command == ntsc_aa_pkg::CMD_FLUSH)) begin
      owed_next = owed_next + 8'd2;
    end
    if (result_beat) begin
      owed_next = owed_next - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owed      <= '0;
      half_open <= 1'b0;
    end else begin
      owed <= owed_next;
      if (result_beat) begin
        half_open <= !result_last;
      end
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data)
                                      && $stable(result_last))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> owed != 8'd0)
    else $error("result beat with no item owing it");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    owed <= 8'(ntsc_aa_pkg::QUEUE_DEPTH))
    else $error("more beats owed than the result queue can hold");

  a_flush_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && half_open |-> result_last)
    else $error("flush pair not closed by its second beat");

endmodule

bind ntsc_artifact_accumulator_unit ntsc_aa_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .item_command(item.command),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .result_data ({result.out_byte_7, result.out_byte_6, result.out_byte_5,
                 result.out_byte_4, result.out_byte_3, result.out_byte_2,
                 result.out_byte_1, result.out_byte_0}),
  .result_last (result.last_of_run)
);

`default_nettype wire
